/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* hw/rtl/psmmn_pkg.sv */
// Constants shared by the per-sensor min/max normalizer.
package psmmn_pkg;

  localparam int SENSOR_COUNT = 16;
  localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  localparam int DATA_W = 8;
  localparam int SEL_W  = 4;
  localparam int NUM_W  = 2 * DATA_W;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [DATA_W-1:0] LOW_RESET  = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] HIGH_RESET = '0;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

/* hw/rtl/psmmn_div.sv */
// Restoring divider: one quotient bit per cycle, quotient known to fit DATA_W bits.
module psmmn_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [psmmn_pkg::NUM_W-1:0]   numer,
  input  logic [psmmn_pkg::DATA_W-1:0]  divisor,
  output logic                          done,
  output logic [psmmn_pkg::DATA_W-1:0]  quotient
);
  import psmmn_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    shreg;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W:0]      trial;
  logic                 qbit;
  logic [DATA_W-1:0]    rem_next;
  logic                 last_step;

  // Remainder stays below the divisor, so the trial fits DATA_W+1 bits.
  always_comb begin
    trial = {rem, shreg[DATA_W-1]};
    qbit  = (trial >= {1'b0, dvs});
    if (qbit) begin
      rem_next = DATA_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DATA_W-1:0];
    end
  end

  assign last_step = busy && (count == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && last_step;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= numer[NUM_W-1:DATA_W];
      shreg <= numer[DATA_W-1:0];
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[DATA_W-2:0], qbit};
    end
  end

  assign quotient = shreg;

endmodule

/* hw/rtl/per_sensor_min_max_normalizer_unit.sv */
// Top level of the per-sensor running min/max normalizer.
// A sample beat widens its sensor's stored min/max to include the reading and
// returns floor(255*(reading-min)/(max-min)); when max equals min the result is
// 0 with flat_range set. A clear beat resets every sensor to min 255, max 0 at
// its accept edge and returns nothing; a sample for a sensor index beyond the
// sensor count is dropped. A normalized sample updates the range at its accept
// edge and then holds in_ready low through these steps in order: forming the
// numerator and span, eight steps plus a handoff in the shared restoring
// divider, and loading the output register. A flat range skips the divider and
// goes from forming the span straight to the load. The load cycle stretches
// while an earlier result still waits for out_ready. The output register lets
// the next beat be accepted while a result still waits for out_ready.
`include "assert_macros.svh"

module per_sensor_min_max_normalizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [psmmn_pkg::SEL_W-1:0]   sensor_index,
  input  logic [psmmn_pkg::DATA_W-1:0]  reading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psmmn_pkg::DATA_W-1:0]  scaled,
  output logic                          flat_range
);
  import psmmn_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0]        state;
  logic [DATA_W-1:0] lowest_seen  [SENSOR_COUNT];
  logic [DATA_W-1:0] highest_seen [SENSOR_COUNT];

  logic [DATA_W-1:0] lo_r, hi_r, rd_r;
  logic [DATA_W-1:0] res_q;
  logic              res_flat;

  logic              in_fire;
  logic              in_range;
  logic              sample_fire;
  logic [IDX_W-1:0]  sel;
  logic [DATA_W-1:0] lo_cur, hi_cur, lo_new, hi_new;

  logic              flat;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] diff;
  logic [NUM_W-1:0]  numer;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic              out_free;

  assign in_ready    = (state == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign sel         = IDX_W'(sensor_index);
  assign in_range    = (32'(sensor_index) < SENSOR_COUNT);
  assign sample_fire = in_fire && (func == FUNC_SAMPLE) && in_range;

  assign lo_cur = lowest_seen[sel];
  assign hi_cur = highest_seen[sel];
  assign lo_new = (reading < lo_cur) ? reading : lo_cur;
  assign hi_new = (reading > hi_cur) ? reading : hi_cur;

  // 255*d as (d << 8) - d.
  assign flat      = (hi_r == lo_r);
  assign span      = hi_r - lo_r;
  assign diff      = rd_r - lo_r;
  assign numer     = {diff, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, diff};
  assign div_start = (state == ST_PREP) && !flat;
  assign out_free  = !out_valid || out_ready;

  psmmn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        lowest_seen[s]  <= LOW_RESET;
        highest_seen[s] <= HIGH_RESET;
      end
    end else if (in_fire) begin
      if (func == FUNC_CLEAR) begin
        for (int s = 0; s < SENSOR_COUNT; s++) begin
          lowest_seen[s]  <= LOW_RESET;
          highest_seen[s] <= HIGH_RESET;
        end
      end else if (in_range) begin
        lowest_seen[sel]  <= lo_new;
        highest_seen[sel] <= hi_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_LOAD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_fire) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (flat) begin
            state <= ST_LOAD;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lo_r <= lo_new;
      hi_r <= hi_new;
      rd_r <= reading;
    end
    if ((state == ST_PREP) && flat) begin
      res_q    <= '0;
      res_flat <= 1'b1;
    end else if ((state == ST_DIV) && div_done) begin
      res_q    <= div_q;
      res_flat <= 1'b0;
    end
    if ((state == ST_LOAD) && out_free) begin
      scaled     <= res_q;
      flat_range <= res_flat;
    end
  end

  `ASSERT_NEVER(a_done_outside_div, clk, rst, div_done && (state != ST_DIV), "done outside DIV")
  `ASSERT_PROP(a_range_ordered, clk, rst, sample_fire |=> (lo_r <= hi_r), "min above max")
  `ASSERT_PROP(a_flat_zero, clk, rst, (out_valid && flat_range) |-> (scaled == '0), "flat nonzero")
  `ASSERT_PROP(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result dropped")

endmodule
